// ----- design/eeb_pkg.sv -----
// Shared types and constants for the extended Euclid (Bezout) core.
// Used by eeb_div_unit and extended_euclid_bezout_core; no dependencies.
package eeb_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int COEF_WIDTH    = OPERAND_WIDTH + 1;
    localparam int CNT_WIDTH     = $clog2(OPERAND_WIDTH + 1);

    typedef logic [OPERAND_WIDTH-1:0] t_opnd;
    typedef logic [COEF_WIDTH-1:0]    t_coef;
    typedef logic [CNT_WIDTH-1:0]     t_cnt;

    // Sequencer states of the top level
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_FIN
    } t_state;

    // Operands handed to the shared divide unit for one Euclid step
    typedef struct packed {
        t_opnd dividend;
        t_opnd divisor;
        t_coef coef_s;
        t_coef coef_t;
    } t_div_req;

    // Results of one Euclid step: remainder and quotient-scaled coefficients
    typedef struct packed {
        t_opnd rem;
        t_coef prod_s;
        t_coef prod_t;
    } t_div_rsp;

endpackage

// ----- design/eeb_div_unit.sv -----
// Shared restoring divider, one quotient bit per cycle, MSB first.
// Also accumulates q*s and q*t (mod 2^COEF_WIDTH) by Horner steps. Uses eeb_pkg.
module eeb_div_unit
    import eeb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_div_req i_req,
    output logic     o_done,
    output t_div_rsp o_rsp
);

    logic                   r_busy;
    logic                   r_done;
    t_cnt                   r_cnt;
    t_opnd                  r_rem;
    t_opnd                  r_quo;
    t_opnd                  r_dvs;
    t_coef                  r_sb;
    t_coef                  r_tb;
    t_coef                  r_acc_s;
    t_coef                  r_acc_t;

    logic [OPERAND_WIDTH:0] w_shifted;
    logic                   w_ge;
    t_opnd                  n_rem;
    t_coef                  n_acc_s;
    t_coef                  n_acc_t;

    // Trial subtract and coefficient accumulate for one quotient bit
    always_comb begin
        w_shifted = {r_rem, r_quo[OPERAND_WIDTH-1]};
        w_ge      = (w_shifted >= {1'b0, r_dvs});
        if (w_ge) begin
            n_rem = t_opnd'(w_shifted - {1'b0, r_dvs});
        end else begin
            n_rem = w_shifted[OPERAND_WIDTH-1:0];
        end
        n_acc_s = {r_acc_s[COEF_WIDTH-2:0], 1'b0} + (w_ge ? r_sb : '0);
        n_acc_t = {r_acc_t[COEF_WIDTH-2:0], 1'b0} + (w_ge ? r_tb : '0);
    end

    // Control: busy flag, bit counter, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= t_cnt'(OPERAND_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == t_cnt'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then advance one bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= '0;
            r_quo   <= i_req.dividend;
            r_dvs   <= i_req.divisor;
            r_sb    <= i_req.coef_s;
            r_tb    <= i_req.coef_t;
            r_acc_s <= '0;
            r_acc_t <= '0;
        end else if (r_busy) begin
            r_rem   <= n_rem;
            r_quo   <= {r_quo[OPERAND_WIDTH-2:0], 1'b0};
            r_acc_s <= n_acc_s;
            r_acc_t <= n_acc_t;
        end
    end

    assign o_done       = r_done;
    assign o_rsp.rem    = r_rem;
    assign o_rsp.prod_s = r_acc_s;
    assign o_rsp.prod_t = r_acc_t;

endmodule

// ----- design/extended_euclid_bezout_core.sv -----
// Extended Euclid core: gcd(a,b) and Bezout coefficients s, t with s*a + t*b = gcd.
// The number of Euclid divisions (steps) per request is data dependent, up to ~46 at 32 bits.
// Each step uses the one shared bit-serial divider; throughput is one request per run.
// Reset (synchronous, active low) returns the sequencer to idle and drops o_valid.
// Depends on eeb_pkg and eeb_div_unit.
module extended_euclid_bezout_core
    import eeb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_opnd i_a_value,
    input  t_opnd i_b_value,
    output logic  o_valid,
    input  logic  i_stall,
    output t_coef o_coef_s,
    output t_coef o_coef_t,
    output t_opnd o_divisor_out,
    output logic  o_range_error
);

    t_state   r_state;
    t_state   n_state;
    t_opnd    r_ra;
    t_opnd    r_rb;
    t_coef    r_sa;
    t_coef    r_sb;
    t_coef    r_ta;
    t_coef    r_tb;
    logic     r_out_valid;
    t_coef    r_out_s;
    t_coef    r_out_t;
    t_opnd    r_out_g;
    logic     r_out_err;

    logic     w_out_free;
    logic     w_accept;
    logic     w_zero_in;
    logic     w_div_start;
    logic     w_div_done;
    logic     w_load_out;
    t_div_req w_req;
    t_div_rsp w_rsp;

    // Shared divide unit
    eeb_div_unit u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_req   (w_req),
        .o_done  (w_div_done),
        .o_rsp   (w_rsp)
    );

    assign w_req.dividend = r_ra;
    assign w_req.divisor  = r_rb;
    assign w_req.coef_s   = r_sb;
    assign w_req.coef_t   = r_tb;

    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = (r_state != ST_IDLE) || !w_out_free;
    assign w_accept   = i_valid && !o_stall;
    assign w_zero_in  = (i_a_value == '0) || (i_b_value == '0);

    // Sequencer: next state and strobes
    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        w_load_out  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && !w_zero_in) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                w_div_start = 1'b1;
                n_state     = ST_RUN;
            end
            ST_RUN: begin
                if (w_div_done) begin
                    n_state = (w_rsp.rem == '0) ? ST_FIN : ST_LOAD;
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Euclid registers: load on accept, shift pair down after each division
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && w_accept) begin
            r_ra <= i_a_value;
            r_rb <= i_b_value;
            r_sa <= t_coef'(1);
            r_sb <= '0;
            r_ta <= '0;
            r_tb <= t_coef'(1);
        end else if (r_state == ST_RUN && w_div_done) begin
            r_ra <= r_rb;
            r_rb <= w_rsp.rem;
            r_sa <= r_sb;
            r_sb <= r_sa - w_rsp.prod_s;
            r_ta <= r_tb;
            r_tb <= r_ta - w_rsp.prod_t;
        end
    end

    // Output register: hold result until the downstream takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out || (w_accept && w_zero_in)) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_zero_in) begin
            r_out_s   <= '0;
            r_out_t   <= '0;
            r_out_g   <= '0;
            r_out_err <= 1'b1;
        end else if (w_load_out) begin
            r_out_s   <= r_sa;
            r_out_t   <= r_ta;
            r_out_g   <= r_ra;
            r_out_err <= 1'b0;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_coef_s      = r_out_s;
    assign o_coef_t      = r_out_t;
    assign o_divisor_out = r_out_g;
    assign o_range_error = r_out_err;

    // Checks
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_range_error) |->
            (o_coef_s == '0 && o_coef_t == '0 && o_divisor_out == '0))
        else $error("error result carries nonzero fields");

    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_range_error) |-> (o_divisor_out != '0))
        else $error("gcd result is zero");

    a_done_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_RUN))
        else $error("divider finished outside run state");

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> (r_rb != '0))
        else $error("division started with zero divisor");

endmodule

// ----- tb/sv/extended_euclid_bezout_core_tb.sv -----
// Self-checking testbench for extended_euclid_bezout_core: gcd and Bezout coefficient checks.
// A queue-fed driver and a monitor, both clocked, are checked against a built-in predictor.
// Depends on eeb_pkg and the design files of the core.
`timescale 1ns / 100ps

module extended_euclid_bezout_core_tb;
    import eeb_pkg::*;

    localparam int RANDOM_ITEMS = 550;
    localparam int STUCK_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 1600;
    localparam int CALM_TAIL    = 50;

    typedef struct {
        t_opnd a;
        t_opnd b;
        bit    drain;  // hold this request until all outstanding results are back
    } t_operand_req;

    typedef struct {
        t_coef s;
        t_coef t;
        t_opnd g;
        logic  err;
    } t_bezout_result;

    logic  i_clk     = 1'b0;
    logic  i_rst_n   = 1'b0;
    logic  i_valid   = 1'b0;
    logic  i_stall   = 1'b0;
    t_opnd i_a_value = '0;
    t_opnd i_b_value = '0;
    logic  o_stall;
    logic  o_valid;
    t_coef o_coef_s;
    t_coef o_coef_t;
    t_opnd o_divisor_out;
    logic  o_range_error;

    t_operand_req   operand_reqs[$];
    t_bezout_result bezout_expect_q[$];
    int errors       = 0;
    int n_sent       = 0;
    int n_rcvd       = 0;
    int n_total      = 0;
    int stuck_cycles = 0;
    int gap_left     = 0;
    int stall_left   = 0;

    extended_euclid_bezout_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_a_value     (i_a_value),
        .i_b_value     (i_b_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_coef_s      (o_coef_s),
        .o_coef_t      (o_coef_t),
        .o_divisor_out (o_divisor_out),
        .o_range_error (o_range_error)
    );

    // Generate the clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Compute gcd and Bezout pair; coefficients wrap mod 2^64, low bits stay exact
    function automatic t_bezout_result bezout_predict(t_opnd a, t_opnd b);
        logic [63:0] ra, rb, rn, q, sa, sb, sn, ta, tb, tn;
        t_bezout_result r;
        r = '{s: '0, t: '0, g: '0, err: 1'b1};
        if (a == '0 || b == '0) return r;
        ra = 64'(a);
        rb = 64'(b);
        sa = 64'd1;
        sb = 64'd0;
        ta = 64'd0;
        tb = 64'd1;
        while (rb != 64'd0) begin
            q  = ra / rb;
            rn = ra - q * rb;
            sn = sa - q * sb;
            tn = ta - q * tb;
            ra = rb;
            rb = rn;
            sa = sb;
            sb = sn;
            ta = tb;
            tb = tn;
        end
        r.s   = sa[COEF_WIDTH-1:0];
        r.t   = ta[COEF_WIDTH-1:0];
        r.g   = ra[OPERAND_WIDTH-1:0];
        r.err = 1'b0;
        return r;
    endfunction

    // Stretches without idling, and none at all near the end
    function automatic bit calm_phase(int count);
        return ((count / 64) % 4 == 3) || (count + CALM_TAIL >= n_total);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t ns: mismatch in %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        errors++;
    endtask

    task automatic add_req(t_opnd a, t_opnd b, bit drain);
        t_operand_req r;
        r.a     = a;
        r.b     = b;
        r.drain = drain;
        operand_reqs.push_back(r);
    endtask

    // Random operand pair with a mix of shapes: full range, small, multiples, shared factors, shifted, zero
    task automatic add_random_req(bit drain);
        t_opnd a, b, g;
        int unsigned k;
        k = $urandom_range(0, 9);
        case (k)
            4: begin
                a = t_opnd'($urandom_range(1, 1000));
                b = t_opnd'($urandom_range(1, 1000));
            end
            5: begin
                b = t_opnd'($urandom_range(1, 65535));
                a = b * t_opnd'($urandom_range(1, 65535));
            end
            6: begin
                g = t_opnd'($urandom_range(2, 4096));
                a = g * t_opnd'($urandom_range(1, 1 << 20));
                b = g * t_opnd'($urandom_range(1, 1 << 20));
            end
            7: begin
                a = t_opnd'($urandom >> $urandom_range(1, 31));
                b = t_opnd'($urandom) | 32'h8000_0000;
            end
            8: begin
                a = t_opnd'($urandom);
                b = t_opnd'($urandom);
                if ($urandom_range(0, 3) == 0) begin
                    if ($urandom_range(0, 1) == 0) a = '0;
                    else b = '0;
                end
            end
            9: begin
                a = t_opnd'($urandom >> $urandom_range(0, 31));
                b = t_opnd'($urandom >> $urandom_range(0, 31));
            end
            default: begin
                a = t_opnd'($urandom);
                b = t_opnd'($urandom);
            end
        endcase
        add_req(a, b, drain);
    endtask

    // Fill the request queue: directed corners first, then random pairs
    initial begin
        add_req(32'd0, 32'd0, 1'b0);
        add_req(32'd0, 32'd5, 1'b0);
        add_req(32'd7, 32'd0, 1'b0);
        add_req(32'd0, 32'hFFFF_FFFF, 1'b0);
        add_req(32'hFFFF_FFFF, 32'd0, 1'b0);
        add_req(32'd1, 32'd1, 1'b0);
        add_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_req(32'hFFFF_FFFF, 32'd1, 1'b0);
        add_req(32'd1, 32'hFFFF_FFFF, 1'b0);
        add_req(32'd12, 32'd4, 1'b0);
        add_req(32'd4, 32'd12, 1'b0);
        add_req(32'd17, 32'd17, 1'b0);
        add_req(32'd1, 32'd2, 1'b0);
        add_req(32'd2, 32'd1, 1'b0);
        add_req(32'd240, 32'd46, 1'b0);
        add_req(32'd35, 32'd64, 1'b0);
        // Consecutive Fibonacci numbers give the longest chain of divisions
        add_req(32'd2971215073, 32'd1836311903, 1'b0);
        add_req(32'd1836311903, 32'd2971215073, 1'b0);
        add_req(32'h8000_0000, 32'h4000_0000, 1'b0);
        add_req(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        add_req(32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
        add_req(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0);
        add_req(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            add_random_req(i == 0 || i == RANDOM_ITEMS / 2);
        end
        n_total = operand_reqs.size();
    end

    // Hold reset low from the start, then release it for good
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver: present requests, hold while stalled, insert random gaps
    always @(posedge i_clk) begin : drive_proc
        logic next_valid;
        t_operand_req head;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left = 0;
        end else begin
            next_valid = i_valid;
            if (i_valid && !o_stall) begin
                bezout_expect_q.push_back(bezout_predict(i_a_value, i_b_value));
                n_sent++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (operand_reqs.size() > 0 &&
                             !(operand_reqs[0].drain && bezout_expect_q.size() != 0)) begin
                    if (!calm_phase(n_sent) && $urandom_range(0, 3) == 0) begin
                        gap_left = $urandom_range(0, 4);
                    end else begin
                        head = operand_reqs.pop_front();
                        i_a_value  <= head.a;
                        i_b_value  <= head.b;
                        next_valid = 1'b1;
                    end
                end
            end
            i_valid <= next_valid;
        end
    end

    // Monitor: check each accepted result against the oldest expectation, drive stall
    always @(posedge i_clk) begin : check_proc
        t_bezout_result want;
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (bezout_expect_q.size() == 0) begin
                    report_mismatch("unrequested result, divisor_out", 64'(o_divisor_out), '0);
                end else begin
                    want = bezout_expect_q.pop_front();
                    if (o_coef_s !== want.s)
                        report_mismatch("coef_s", 64'(o_coef_s), 64'(want.s));
                    if (o_coef_t !== want.t)
                        report_mismatch("coef_t", 64'(o_coef_t), 64'(want.t));
                    if (o_divisor_out !== want.g)
                        report_mismatch("divisor_out", 64'(o_divisor_out), 64'(want.g));
                    if (o_range_error !== want.err)
                        report_mismatch("range_error", 64'(o_range_error), 64'(want.err));
                end
                n_rcvd++;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (!calm_phase(n_rcvd) && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(0, 4);
                i_stall    <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves a request or a result
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    // Wait for all requests and results, let the core settle, then report
    initial begin
        @(posedge i_rst_n);
        while (!(operand_reqs.size() == 0 && !i_valid && bezout_expect_q.size() == 0) &&
               stuck_cycles < STUCK_LIMIT)
            @(posedge i_clk);
        if (stuck_cycles < STUCK_LIMIT)
            repeat (TAIL_CYCLES) @(posedge i_clk);
        if (stuck_cycles >= STUCK_LIMIT || errors != 0 || bezout_expect_q.size() != 0) begin
            $display("** extended_euclid_bezout_core: FAILED **");
        end else begin
            $display("** extended_euclid_bezout_core: PASSED **");
        end
        $finish;
    end

endmodule
